// ===== design/lhii_pkg.sv =====
package lhii_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_LINES  = 64;

  localparam int IDX_W  = 6;
  localparam int OUT_W  = 7;
  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int LN_W   = $clog2(MAX_LINES);
  localparam int DEG_W  = $clog2(MAX_LINES + 1);
  localparam int SIZE_W = $clog2(MAX_POINTS + 1);
  localparam int PLL_AW = PT_W + LN_W;

  typedef logic [MAX_LINES-1:0] mark_t;

  typedef struct packed {
    logic start;
    logic load;
    logic check;
    logic update;
    logic clr_walk;
    logic commit;
    logic reject;
    logic push;
  } lhii_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic full;
    logic walk_done;
    logic hit;
    logic slot_free;
  } lhii_stat_t;

endpackage

// ===== design/linear_hypergraph_incidence_insert_unit.sv =====
// channel   beat fields                              handshake
// item      point_index, line_index                  item_valid / item_ready
// result    accepted, point_degree, line_size        result_valid / result_ready
//
// one item at a time, one slot of the point's line list read a cycle; an added item walks the
// point's lines twice (check, update), one refused by the check walk once, one out of range
// or full never; the next item is taken after the result is pushed at the earliest
// reset clears counts and share marks through per-entry valid bits, no clearing pass
// the result register parts the sides: a new item is taken while a result waits,
// and a finished item holds in its last state until the result register frees
module linear_hypergraph_incidence_insert_unit import lhii_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [IDX_W-1:0] point_index,
  input  logic [IDX_W-1:0] line_index,
  output logic             result_valid,
  input  logic             result_ready,
  output logic             accepted,
  output logic [OUT_W-1:0] point_degree,
  output logic [OUT_W-1:0] line_size
);

  // command and status between sequencer and datapath
  lhii_cmd_t  cmd;
  lhii_stat_t stat;

  // sequencer: load, decide, check walk, update walk, commit or refuse, result
  lhii_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: incidence memories, share marks, walk pipeline, result register
  lhii_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .point_index  (point_index),
    .line_index   (line_index),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .accepted     (accepted),
    .point_degree (point_degree),
    .line_size    (line_size)
  );

endmodule

// ===== design/lhii_ctrl.sv =====
module lhii_ctrl import lhii_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  lhii_stat_t stat,
  output lhii_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DECIDE,
    S_CHECK,
    S_UPDATE,
    S_COMMIT,
    S_REJECT,
    S_RESULT
  } state_t;

  state_t state;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.start    = (state == S_IDLE) && item_valid;
    cmd.load     = (state == S_LOAD);
    cmd.check    = (state == S_CHECK);
    cmd.update   = (state == S_UPDATE);
    cmd.clr_walk = (state == S_CHECK) && stat.walk_done && !stat.hit;
    cmd.commit   = (state == S_COMMIT);
    cmd.reject   = (state == S_REJECT);
    cmd.push     = (state == S_RESULT) && stat.slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) state <= S_LOAD;
        end
        S_LOAD: state <= S_DECIDE;
        S_DECIDE: begin
          if (stat.range_bad || stat.full) state <= S_REJECT;
          else                             state <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.walk_done) begin
            if (stat.hit) state <= S_REJECT;
            else          state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (stat.walk_done) state <= S_COMMIT;
        end
        S_COMMIT: state <= S_RESULT;
        S_REJECT: state <= S_RESULT;
        S_RESULT: begin
          if (stat.slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lhii_datapath.sv =====
module lhii_datapath import lhii_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] point_index,
  input  logic [IDX_W-1:0] line_index,
  input  lhii_cmd_t        cmd,
  output lhii_stat_t       stat,
  output logic             result_valid,
  input  logic             result_ready,
  output logic             accepted,
  output logic [OUT_W-1:0] point_degree,
  output logic [OUT_W-1:0] line_size
);

  // memories
  mark_t              marks [MAX_LINES];
  logic [LN_W-1:0]    pll   [1 << PLL_AW];
  logic [DEG_W-1:0]   deg_mem  [MAX_POINTS];
  logic [SIZE_W-1:0]  size_mem [MAX_LINES];

  // valid bits, cleared at reset
  logic [MAX_LINES-1:0]  mark_vld;
  logic [MAX_POINTS-1:0] deg_vld;
  logic [MAX_LINES-1:0]  size_vld;

  // registered read data
  mark_t             marks_rd;
  logic              marks_rd_vld;
  logic [DEG_W-1:0]  deg_rd;
  logic              deg_rd_vld;
  logic [SIZE_W-1:0] size_rd;
  logic              size_rd_vld;
  logic [LN_W-1:0]   pll_rd;

  // item registers
  logic [PT_W-1:0]   p_q;
  logic [LN_W-1:0]   l_q;
  logic              range_bad;
  logic [DEG_W-1:0]  deg_q;
  logic [SIZE_W-1:0] size_q;
  mark_t             markl;

  // walk
  logic [DEG_W-1:0]  k;
  logic              pv;
  logic              pv2;
  logic [LN_W-1:0]   oth2;
  logic              hit;
  logic              walking;
  logic              issue;

  // held result
  logic              res_ok;
  logic [OUT_W-1:0]  res_deg;
  logic [OUT_W-1:0]  res_size;

  // marks write port
  logic              mw_en;
  logic [LN_W-1:0]   mw_addr;
  mark_t             mw_data;
  logic [LN_W-1:0]   mr_addr;

  assign walking = cmd.check || cmd.update;
  assign issue   = walking && (k < deg_q);

  assign mr_addr = cmd.start ? LN_W'(line_index) : pll_rd;

  always_comb begin
    mw_en   = 1'b0;
    mw_addr = oth2;
    mw_data = (marks_rd_vld ? marks_rd : '0) | (mark_t'(1) << l_q);
    if (cmd.commit) begin
      mw_en   = 1'b1;
      mw_addr = l_q;
      mw_data = markl;
    end else if (cmd.update && pv2) begin
      mw_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    marks_rd <= marks[mr_addr];
    deg_rd   <= deg_mem[PT_W'(point_index)];
    size_rd  <= size_mem[LN_W'(line_index)];
    if (mw_en) marks[mw_addr] <= mw_data;
    if (issue) pll_rd <= pll[{p_q, k[LN_W-1:0]}];
    if (cmd.commit) begin
      pll[{p_q, deg_q[LN_W-1:0]}] <= l_q;
      deg_mem[p_q]  <= deg_q + 1'b1;
      size_mem[l_q] <= size_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_vld <= '0;
      deg_vld  <= '0;
      size_vld <= '0;
    end else begin
      if (mw_en) mark_vld[mw_addr] <= 1'b1;
      if (cmd.commit) begin
        deg_vld[p_q]  <= 1'b1;
        size_vld[l_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    marks_rd_vld <= mark_vld[mr_addr];
    deg_rd_vld   <= deg_vld[PT_W'(point_index)];
    size_rd_vld  <= size_vld[LN_W'(line_index)];
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pv  <= 1'b0;
      pv2 <= 1'b0;
      k   <= '0;
      hit <= 1'b0;
    end else begin
      if (cmd.start) begin
        p_q       <= PT_W'(point_index);
        l_q       <= LN_W'(line_index);
        range_bad <= !((32'(point_index) < 32'(MAX_POINTS)) &&
                       (32'(line_index) < 32'(MAX_LINES)));
      end
      if (cmd.load) begin
        deg_q  <= deg_rd_vld  ? deg_rd  : '0;
        size_q <= size_rd_vld ? size_rd : '0;
        markl  <= marks_rd_vld ? marks_rd : '0;
        k      <= '0;
        hit    <= 1'b0;
        pv     <= 1'b0;
        pv2    <= 1'b0;
      end else if (cmd.clr_walk) begin
        k   <= '0;
        pv  <= 1'b0;
        pv2 <= 1'b0;
      end else begin
        if (issue) k <= k + 1'b1;
        pv  <= issue;
        pv2 <= cmd.update && pv;
        // check: repeat or line already sharing with one of the point's lines
        if (cmd.check && pv && ((pll_rd == l_q) || markl[pll_rd])) hit <= 1'b1;
        if (cmd.update && pv) begin
          markl[pll_rd] <= 1'b1;
          oth2          <= pll_rd;
        end
      end
    end
  end

  // result hold and output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_ok   <= 1'b1;
      res_deg  <= OUT_W'(deg_q + 1'b1);
      res_size <= OUT_W'(size_q + 1'b1);
    end else if (cmd.reject) begin
      res_ok   <= 1'b0;
      res_deg  <= range_bad ? '0 : OUT_W'(deg_q);
      res_size <= range_bad ? '0 : OUT_W'(size_q);
    end
    if (cmd.push) begin
      accepted     <= res_ok;
      point_degree <= res_deg;
      line_size    <= res_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  assign stat.range_bad = range_bad;
  assign stat.full      = (deg_q >= DEG_W'(MAX_LINES)) || (size_q >= SIZE_W'(MAX_POINTS));
  assign stat.walk_done = walking && !issue && !pv && !pv2;
  assign stat.hit       = hit;
  assign stat.slot_free = !result_valid || result_ready;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb import lhii_pkg::*;;

  localparam int RANDOM_ITEMS   = 900;
  localparam int HOLD_CYCLES    = 400;
  // worst item: full walk of 63 slots twice plus overhead
  localparam int DRAIN_CYCLES   = 2 * MAX_LINES + 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic             accepted;
    logic [OUT_W-1:0] point_degree;
    logic [OUT_W-1:0] line_size;
  } decision_t;

  typedef enum {SEG_LINE_SWEEP, SEG_POINT_SWEEP, SEG_SPARSE, SEG_DENSE} segment_t;

  // mirror of the incidence store, plus the decisions still owed by the block
  class incidence_predictor;
    mark_t           shares_with [MAX_LINES];
    logic [LN_W-1:0] lines_on_point [MAX_POINTS][MAX_LINES];
    int              degree_of [MAX_POINTS];
    int              size_of [MAX_LINES];
    decision_t       owed_decisions [$];
    int              mismatches;

    function new();
      foreach (shares_with[i]) shares_with[i] = '0;
      foreach (degree_of[i]) degree_of[i] = 0;
      foreach (size_of[i]) size_of[i] = 0;
      mismatches = 0;
    endfunction

    function void note_proposal(logic [IDX_W-1:0] pt, logic [IDX_W-1:0] ln);
      decision_t d;
      logic      refuse;
      int        other;
      d = '{default: '0};
      // out-of-range index: refused with zero counts, store untouched
      if (pt >= MAX_POINTS || ln >= MAX_LINES) begin
        owed_decisions.push_back(d);
        return;
      end
      refuse = degree_of[pt] >= MAX_LINES || size_of[ln] >= MAX_POINTS;
      // repeat, or the new line already meets one of the point's lines
      for (int k = 0; k < degree_of[pt] && !refuse; k++) begin
        other = lines_on_point[pt][k];
        if (other == ln || shares_with[ln][other]) refuse = 1'b1;
      end
      if (!refuse) begin
        for (int k = 0; k < degree_of[pt]; k++) begin
          other = lines_on_point[pt][k];
          shares_with[other][ln] = 1'b1;
          shares_with[ln][other] = 1'b1;
        end
        lines_on_point[pt][degree_of[pt]] = ln;
        degree_of[pt]++;
        size_of[ln]++;
      end
      d.accepted     = !refuse;
      d.point_degree = OUT_W'(degree_of[pt]);
      d.line_size    = OUT_W'(size_of[ln]);
      owed_decisions.push_back(d);
    endfunction

    function void check_decision(logic acc, logic [OUT_W-1:0] deg, logic [OUT_W-1:0] sz);
      decision_t want;
      if (owed_decisions.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: accepted %0d",
                 $time, acc, " point_degree %0d line_size %0d", deg, sz);
        mismatches++;
        return;
      end
      want = owed_decisions.pop_front();
      if (acc !== want.accepted) begin
        $display("%0t: accepted expected %0d actual %0d", $time, want.accepted, acc);
        mismatches++;
      end
      if (deg !== want.point_degree) begin
        $display("%0t: point_degree expected %0d actual %0d", $time, want.point_degree, deg);
        mismatches++;
      end
      if (sz !== want.line_size) begin
        $display("%0t: line_size expected %0d actual %0d", $time, want.line_size, sz);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return owed_decisions.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  logic [IDX_W-1:0] point_index;
  logic [IDX_W-1:0] line_index;
  logic             result_valid;
  logic             result_ready;
  logic             accepted;
  logic [OUT_W-1:0] point_degree;
  logic [OUT_W-1:0] line_size;

  incidence_predictor predictor = new();

  int send_idle;
  int recv_idle;
  bit hold_req;
  bit hold_done;
  int sent;
  int idle_cycles;

  linear_hypergraph_incidence_insert_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .point_index  (point_index),
    .line_index   (line_index),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .accepted     (accepted),
    .point_degree (point_degree),
    .line_size    (line_size)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // one proposal beat: random gaps first, then hold valid until taken
  task automatic offer_proposal(input logic [IDX_W-1:0] pt, input logic [IDX_W-1:0] ln);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    point_index <= pt;
    line_index  <= ln;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predictor.note_proposal(pt, ln);
    sent++;
  endtask

  task automatic run_segment(input segment_t seg);
    int start;
    int stride;
    int pbase;
    int lbase;
    start  = $urandom_range(63);
    stride = 2 * $urandom_range(31) + 1;  // odd stride visits every index once
    pbase  = $urandom_range(63);
    lbase  = $urandom_range(63);
    case (seg)
      SEG_LINE_SWEEP: begin
        for (int i = 0; i < MAX_POINTS; i++)
          offer_proposal(IDX_W'(start + i * stride), IDX_W'(lbase));
      end
      SEG_POINT_SWEEP: begin
        for (int i = 0; i < MAX_LINES; i++)
          offer_proposal(IDX_W'(pbase), IDX_W'(start + i * stride));
      end
      SEG_SPARSE: begin
        for (int i = 0; i < 16; i++)
          offer_proposal(IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)));
      end
      default: begin
        // small corner of the store: many repeats and linearity refusals
        for (int i = 0; i < 16; i++)
          offer_proposal(IDX_W'(pbase + $urandom_range(7)), IDX_W'(lbase + $urandom_range(7)));
      end
    endcase
  endtask

  function automatic segment_t pick_segment();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return SEG_LINE_SWEEP;
    if (roll == 1) return SEG_POINT_SWEEP;
    if (roll < 6) return SEG_SPARSE;
    return SEG_DENSE;
  endfunction

  // result side: random ready, or one long hold-off on request
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      predictor.check_decision(accepted, point_degree, line_size);
  end

  // watchdog on beats of either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("linear_hypergraph_incidence_insert_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int random_start;
    rst         = 1'b1;
    item_valid  = 1'b0;
    point_index = '0;
    line_index  = '0;
    send_idle   = 24;
    recv_idle   = 51;
    hold_req    = 1'b0;
    sent        = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: index extremes, repeats, linearity refusals
    offer_proposal(0, 0);
    offer_proposal(0, 0);
    offer_proposal(63, 63);
    offer_proposal(63, 0);
    offer_proposal(0, 63);
    offer_proposal(1, 0);
    offer_proposal(1, 63);
    offer_proposal(2, 63);
    offer_proposal(42, 21);
    offer_proposal(21, 42);
    offer_proposal(0, 1);
    offer_proposal(0, 2);
    offer_proposal(0, 3);
    offer_proposal(5, 1);
    offer_proposal(5, 2);
    offer_proposal(5, 42);
    offer_proposal(21, 21);
    offer_proposal(42, 42);
    offer_proposal(63, 42);
    offer_proposal(63, 63);

    random_start = sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 24;
          recv_idle = 51;
          run_segment(SEG_LINE_SWEEP);
        end
        1: begin
          send_idle = 51;
          recv_idle = 24;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          hold_req  = 1'b1;  // sender keeps offering while results back up
        end
      endcase
      while (sent < random_start + (phase + 1) * RANDOM_ITEMS / 3)
        run_segment(pick_segment());
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (predictor.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predictor.mismatches == 0 && predictor.outstanding() == 0)
      $display("linear_hypergraph_incidence_insert_unit regression: pass");
    else
      $display("linear_hypergraph_incidence_insert_unit regression: fail");
    $finish;
  end

endmodule
